/* hdl/frequency_to_nearest_note_macros.svh */
// Assertion macros for the frequency to nearest note block.
// Define ASSERT_OFF to compile every check away.
`ifndef FREQUENCY_TO_NEAREST_NOTE_MACROS_SVH
`define FREQUENCY_TO_NEAREST_NOTE_MACROS_SVH
`ifndef ASSERT_OFF
`define FTNN_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FTNN_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FTNN_ASSERT(label, clk, rst_n, prop, msg)
`define FTNN_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* hdl/ftnn_pkg.sv */
// Shared constants, types and elaboration-time functions for the note quantizer.
// Used by ftnn_log2, ftnn_exp2 and frequency_to_nearest_note.
`timescale 1ns / 1ps
package ftnn_pkg;
	localparam int FREQ_W = 24;
	localparam int REF_W = 18;
	localparam int OFF_W = 15;
	localparam int LOG_W = 21;
	localparam int LOG_STAGES = 16;
	localparam int EXP_STAGES = 16;
	localparam int CENTS_W = 23;
	localparam int NFREQ_W = 25;
	localparam int OCT_W = 5;
	localparam int PC_W = 4;

	localparam logic CFG_PITCH = 1'b0;
	localparam logic CFG_OFFSET = 1'b1;

	localparam logic [REF_W-1:0] PITCH_RESET = 18'd112640;
	localparam logic [NFREQ_W-1:0] FREQ_SAT = 25'h1FFFFFF;

	// floor(nc*1024/1875) with a bias that keeps the dividend positive
	localparam logic [23:0] DIV_BIAS = 24'd4194375;    // 1875 * 2237
	localparam logic [31:0] DIV_RECIP = 32'd2345624805; // floor(2^42 / 1875)
	localparam logic [10:0] DIV_CONST = 11'd1875;
	localparam logic [24:0] EXP_BIAS = 25'd2290688;    // 1024 * 2237

	typedef struct packed {
		logic zero;
		logic signed [OFF_W-1:0] off;
		logic [REF_W-1:0] ref_p;
	} log_sb_t;

	typedef struct packed {
		logic zero;
		logic [PC_W-1:0] pc;
		logic signed [OCT_W-1:0] oct;
		logic sharp;
		logic signed [CENTS_W-1:0] nc;
		logic signed [8:0] k;
		logic [REF_W-1:0] ref_p;
	} exp_sb_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] res;
		logic [63:0] vv;
		logic [63:0] b;
		res = '0;
		vv = v;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (b > vv) begin
				b = b >> 2;
			end
		end
		for (int i = 0; i < 32; i++) begin
			if (b != 0) begin
				if (vv >= res + b) begin
					vv = vv - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
		end
		return res;
	endfunction

	// 2^(2^-j) in Q30, built by repeated integer square roots
	function automatic logic [30:0] exp_root(input int j);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int i = 1; i <= 16; i++) begin
			if (i <= j) begin
				r = isqrt64(r << 30);
			end
		end
		return r[30:0];
	endfunction

	function automatic logic pc_is_sharp(input logic [PC_W-1:0] pc);
		logic s;
		unique case (pc)
			4'd1, 4'd3, 4'd6, 4'd8, 4'd10: s = 1'b1;
			default: s = 1'b0;
		endcase
		return s;
	endfunction
endpackage

/* hdl/ftnn_log2.sv */
// Pipelined log2 in Q16: leading-one normalize, then one squaring per stage.
// Depends on ftnn_pkg.
`timescale 1ns / 1ps
module ftnn_log2 import ftnn_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [FREQ_W-1:0] x,
	output logic [LOG_W-1:0]  log_q16
);
	logic [4:0]  p_c;
	logic [30:0] m_c;
	logic [30:0] m_s  [0:LOG_STAGES];
	logic [4:0]  p_s  [0:LOG_STAGES];
	logic [15:0] fr_s [0:LOG_STAGES];

	always_comb begin
		p_c = '0;
		for (int i = 1; i < FREQ_W; i++) begin
			if (x[i]) begin
				p_c = 5'(i);
			end
		end
		m_c = 31'(x) << (5'd30 - p_c);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s[0] <= m_c;
			p_s[0] <= p_c;
			fr_s[0] <= '0;
		end
	end

	for (genvar g = 0; g < LOG_STAGES; g++) begin : g_sq
		logic [61:0] sq;
		logic [31:0] hi;
		assign sq = 62'(m_s[g]) * 62'(m_s[g]);
		assign hi = sq[61:30];
		always_ff @(posedge clk) begin
			if (en) begin
				// a square at or above 2.0 yields a one bit and is halved
				m_s[g+1] <= hi[31] ? hi[31:1] : hi[30:0];
				p_s[g+1] <= p_s[g];
				fr_s[g+1] <= {fr_s[g][14:0], hi[31]};
			end
		end
	end

	assign log_q16 = {p_s[LOG_STAGES], fr_s[LOG_STAGES]};
endmodule

/* hdl/ftnn_exp2.sv */
// Pipelined 2^f in Q30 for a Q16 fraction: one conditional root product per stage.
// Depends on ftnn_pkg.
`timescale 1ns / 1ps
module ftnn_exp2 import ftnn_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] frac,
	output logic [30:0] mant
);
	logic [30:0] m_s [0:EXP_STAGES];
	logic [15:0] f_s [0:EXP_STAGES];

	assign m_s[0] = 31'h4000_0000;
	assign f_s[0] = frac;

	for (genvar g = 0; g < EXP_STAGES; g++) begin : g_mul
		localparam logic [30:0] ROOT = exp_root(g + 1);
		logic [61:0] pr;
		assign pr = 62'(m_s[g]) * 62'(ROOT);
		always_ff @(posedge clk) begin
			if (en) begin
				// walk the fraction from its top bit down
				m_s[g+1] <= f_s[g][15-g] ? pr[60:30] : m_s[g];
				f_s[g+1] <= f_s[g];
			end
		end
	end

	assign mant = m_s[EXP_STAGES];
endmodule

/* hdl/frequency_to_nearest_note.sv */
// Top level of the equal-temperament note quantizer.
// Depends on ftnn_pkg, ftnn_log2, ftnn_exp2 and the assertion macro header.
`timescale 1ns / 1ps
`include "frequency_to_nearest_note_macros.svh"
// Usage:
//   s_axis carries one frequency word (1/256 Hz) per beat; m_axis returns one
//   result word per input word, in order. tuser high marks a meaningful result;
//   a zero frequency returns tuser low and an all-zero tdata.
//   cfg_we/cfg_index/cfg_data write the reference pitch (index 0) and the
//   cents offset (index 1); write them only while the pipeline is empty.
// Stages and throughput:
//   From input accept to output valid a word passes 17 log2 stages (normalize
//   and 16 squarings), 5 stages of rounding, note split and constant division,
//   16 exp2 stages, the reference multiply and the output shift register.
//   One word per cycle is accepted while the output side keeps up.
// Reset:
//   arst_n clears all valid bits and loads 440 Hz and a zero offset.
// Stall:
//   tready low on m_axis with a result held freezes the whole pipeline and
//   drops s_axis tready; nothing is lost or repeated.
module frequency_to_nearest_note import ftnn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // [23:0] freq
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [3:0] pitch_class, [8:4] octave_number, [9] is_sharp,
	// [32:10] note_cents, [57:33] note_frequency, [63:58] zero
	output logic [63:0] m_axis_tdata,
	output logic        m_axis_tuser,  // [0] valid_res
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [17:0] cfg_data
);
	logic [REF_W-1:0] pitch_q;
	logic signed [OFF_W-1:0] offset_q;
	logic adv;
	logic [REF_W-1:0] ref_c;
	logic [LOG_W-1:0] lf, lr;

	log_sb_t lsb_s [0:LOG_STAGES];
	logic lv_s [0:LOG_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= PITCH_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PITCH: pitch_q <= cfg_data;
				CFG_OFFSET: offset_q <= cfg_data[OFF_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign ref_c = (pitch_q == '0) ? REF_W'(1) : pitch_q;

	ftnn_log2 u_log_f (.clk(clk), .en(adv), .x(s_axis_tdata), .log_q16(lf));
	ftnn_log2 u_log_r (.clk(clk), .en(adv), .x(FREQ_W'(ref_c)), .log_q16(lr));

	// sideband that rides alongside the log lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LOG_STAGES; i++) begin
				lv_s[i] <= 1'b0;
			end
		end else if (adv) begin
			lv_s[0] <= s_axis_tvalid;
			for (int i = 1; i <= LOG_STAGES; i++) begin
				lv_s[i] <= lv_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			lsb_s[0] <= '{zero: (s_axis_tdata == '0), off: offset_q, ref_p: ref_c};
			for (int i = 1; i <= LOG_STAGES; i++) begin
				lsb_s[i] <= lsb_s[i-1];
			end
		end
	end

	// stage 1: semitone distance, rounded half away from zero
	logic signed [21:0] d_c;
	logic signed [25:0] s12_c;
	logic [25:0] sabs_c;
	logic [9:0] na_c;
	logic signed [9:0] n_s1;
	log_sb_t sb_s1;
	logic v_s1;

	always_comb begin
		d_c = $signed({1'b0, lf}) - $signed({1'b0, lr});
		s12_c = (26'(d_c) <<< 3) + (26'(d_c) <<< 2);
		sabs_c = s12_c[25] ? 26'(-s12_c) : 26'(s12_c);
		na_c = 10'((sabs_c + 26'd32768) >> 16);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1 <= s12_c[25] ? -$signed(na_c) : $signed(na_c);
			sb_s1 <= lsb_s[LOG_STAGES];
		end
	end

	// stage 2: octave, pitch class and note cents
	logic [9:0] t_c;
	logic [25:0] tq_c;
	logic [5:0] q12_c;
	logic [9:0] rem_c;
	logic signed [6:0] oct_c;
	logic signed [OCT_W-1:0] octc_c;
	logic signed [24:0] nc_c;
	exp_sb_t x_s2;
	logic v_s2;

	always_comb begin
		t_c = 10'(n_s1 + 10'sd417);
		tq_c = 26'(t_c) * 26'd43691;
		q12_c = tq_c[24:19];
		rem_c = t_c - 10'(q12_c) * 10'd12;
		oct_c = $signed({1'b0, q12_c}) - 7'sd30;
		if (oct_c > 7'sd15) begin
			octc_c = 5'sd15;
		end else if (oct_c < -7'sd16) begin
			octc_c = -5'sd16;
		end else begin
			octc_c = oct_c[4:0];
		end
		nc_c = 25'(n_s1) * 25'sd10000 + 25'(sb_s1.off);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2.zero <= sb_s1.zero;
			x_s2.pc <= rem_c[3:0];
			x_s2.oct <= octc_c;
			x_s2.sharp <= pc_is_sharp(rem_c[3:0]);
			x_s2.nc <= nc_c[CENTS_W-1:0];
			x_s2.k <= '0;
			x_s2.ref_p <= sb_s1.ref_p;
		end
	end

	// stages 3 to 5: exponent floor(nc*1024/1875) by reciprocal and correction
	logic [23:0] u_c;
	logic [55:0] dp_s3;
	logic [23:0] u_s3;
	exp_sb_t x_s3;
	logic v_s3;
	logic [22:0] q0_s4;
	logic [33:0] q0x_s4;
	logic [23:0] u_s4;
	exp_sb_t x_s4;
	logic v_s4;
	logic [33:0] r_c;
	logic [22:0] q_c;
	logic signed [24:0] e_c;
	exp_sb_t x5_c;
	logic [15:0] f_s5;
	exp_sb_t x_s5;
	logic v_s5;

	assign u_c = 24'($signed(25'(x_s2.nc)) + $signed({1'b0, DIV_BIAS}));

	always_ff @(posedge clk) begin
		if (adv) begin
			dp_s3 <= 56'(u_c) * 56'(DIV_RECIP);
			u_s3 <= u_c;
			x_s3 <= x_s2;
			q0_s4 <= dp_s3[54:32];
			q0x_s4 <= 34'(dp_s3[54:32]) * 34'(DIV_CONST);
			u_s4 <= u_s3;
			x_s4 <= x_s3;
		end
	end

	always_comb begin
		r_c = {u_s4, 10'b0} - q0x_s4;
		q_c = q0_s4 + 23'(r_c >= 34'(DIV_CONST));
		e_c = $signed(25'(q_c)) - $signed(EXP_BIAS);
		x5_c = x_s4;
		x5_c.k = e_c[24:16];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s5 <= e_c[15:0];
			x_s5 <= x5_c;
		end
	end

	// exp2 lane and its sideband
	logic [30:0] mant;
	exp_sb_t xsb_s [0:EXP_STAGES-1];
	logic xv_s [0:EXP_STAGES-1];

	ftnn_exp2 u_exp (.clk(clk), .en(adv), .frac(f_s5), .mant(mant));

	always_ff @(posedge clk) begin
		if (adv) begin
			xsb_s[0] <= x_s5;
			for (int i = 1; i < EXP_STAGES; i++) begin
				xsb_s[i] <= xsb_s[i-1];
			end
		end
	end

	// stage 6: scale by the reference pitch
	logic [48:0] fp_s6;
	exp_sb_t x_s6;
	logic v_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			fp_s6 <= 49'(xsb_s[EXP_STAGES-1].ref_p) * 49'(mant);
			x_s6 <= xsb_s[EXP_STAGES-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			for (int i = 0; i < EXP_STAGES; i++) begin
				xv_s[i] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= lv_s[LOG_STAGES];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			xv_s[0] <= v_s5;
			for (int i = 1; i < EXP_STAGES; i++) begin
				xv_s[i] <= xv_s[i-1];
			end
			v_s6 <= xv_s[EXP_STAGES-1];
		end
	end

	// output stage: shift by 30-k with round half up, saturate
	logic signed [9:0] sh_c;
	logic [5:0] amt_c;
	logic [48:0] tmp_c;
	logic [49:0] rr_c;
	logic [NFREQ_W-1:0] nf_c;

	always_comb begin
		sh_c = 10'sd30 - 10'(x_s6.k);
		amt_c = '0;
		tmp_c = '0;
		rr_c = '0;
		nf_c = '0;
		if (sh_c > 10'sd0) begin
			if (sh_c >= 10'sd63) begin
				nf_c = '0;
			end else begin
				amt_c = 6'(sh_c - 10'sd1);
				tmp_c = fp_s6 >> amt_c;
				rr_c = (50'(tmp_c) + 50'd1) >> 1;
				nf_c = (rr_c > 50'(FREQ_SAT)) ? FREQ_SAT : rr_c[NFREQ_W-1:0];
			end
		end else if (sh_c == 10'sd0) begin
			nf_c = (fp_s6 > 49'(FREQ_SAT)) ? FREQ_SAT : fp_s6[NFREQ_W-1:0];
		end else if (sh_c < -10'sd25) begin
			nf_c = FREQ_SAT;
		end else begin
			amt_c = 6'(-sh_c);
			if ((fp_s6 >> (6'd25 - amt_c)) != '0) begin
				nf_c = FREQ_SAT;
			end else begin
				nf_c = NFREQ_W'(fp_s6 << amt_c);
			end
		end
	end

	logic out_v_q;
	logic out_res_q;
	logic [PC_W-1:0] out_pc_q;
	logic signed [OCT_W-1:0] out_oct_q;
	logic out_sharp_q;
	logic signed [CENTS_W-1:0] out_nc_q;
	logic [NFREQ_W-1:0] out_nf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// zero frequency clears every field
			out_res_q <= !x_s6.zero;
			out_pc_q <= x_s6.zero ? '0 : x_s6.pc;
			out_oct_q <= x_s6.zero ? '0 : x_s6.oct;
			out_sharp_q <= x_s6.zero ? 1'b0 : x_s6.sharp;
			out_nc_q <= x_s6.zero ? '0 : x_s6.nc;
			out_nf_q <= x_s6.zero ? '0 : nf_c;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tuser = out_res_q;
	assign m_axis_tdata = {6'b0, out_nf_q, out_nc_q, out_sharp_q, out_oct_q, out_pc_q};

	`FTNN_ASSERT(a_zero_clears, clk, arst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0, "zero frequency result not cleared")
	`FTNN_ASSERT(a_sharp_match, clk, arst_n, m_axis_tvalid && m_axis_tuser |-> out_sharp_q == (out_pc_q == 4'd1 || out_pc_q == 4'd3 || out_pc_q == 4'd6 || out_pc_q == 4'd8 || out_pc_q == 4'd10), "sharp flag disagrees with pitch class")
	`FTNN_NEVER(a_pc_range, clk, arst_n, m_axis_tvalid && out_pc_q > 4'd11, "pitch class out of range")
endmodule

/* test/frequency_to_nearest_note_test.sv */
// Self-checking testbench for frequency_to_nearest_note: drives frequency words,
// predicts each note result in fixed point and compares it field by field.
// Depends on ftnn_pkg and the frequency_to_nearest_note RTL.
`timescale 1ns / 1ps
module frequency_to_nearest_note_test;
	import ftnn_pkg::*;

	localparam int LATENCY = 40;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic valid_res;
		logic [3:0] pitch_class;
		logic [4:0] octave_number;
		logic is_sharp;
		logic [22:0] note_cents;
		logic [24:0] note_frequency;
	} note_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we = 1'b0;
	logic cfg_index = CFG_PITCH;
	logic [17:0] cfg_data = '0;

	frequency_to_nearest_note dut (.*);

	logic [23:0] freq_queue[$];
	note_t note_queue[$];
	logic [17:0] pitch_reg = PITCH_RESET;
	logic signed [14:0] offset_reg = '0;
	int send_idle = 10;
	int recv_idle = 62;
	int hold_cycles = 0;
	int mismatches = 0;
	longint cycles = 0;
	logic [63:0] roots[17];

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint sq_root(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint log2_fixed(longint unsigned x);
		longint unsigned m;
		longint p, frac;
		p = 0;
		frac = 0;
		while (p < 31 && (x >> (p + 1)) != 0) p++;
		m = x << (30 - p);
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd1 << 31)) begin
				frac |= 1;
				m >>= 1;
			end
		end
		return (p << 16) | frac;
	endfunction

	function automatic longint fdiv(longint a, longint b);
		if (a >= 0) return a / b;
		return -((-a + b - 1) / b);
	endfunction

	function automatic longint unsigned note_hz(longint unsigned r, longint nc);
		longint unsigned mant, prod;
		longint e, k, s, f;
		mant = 64'd1 << 30;
		e = fdiv(nc * 65536, 120000);
		k = fdiv(e, 65536);
		f = e - k * 65536;
		for (int j = 1; j <= 16; j++)
			if ((f >> (16 - j)) & 1) mant = (mant * roots[j]) >> 30;
		prod = r * mant;
		s = 30 - k;
		if (s > 0) begin
			if (s >= 63) return 0;
			prod = (prod + (64'd1 << (s - 1))) >> s;
		end else if (s < 0) begin
			if (-s > 25 || prod > (64'd33554431 >> (-s))) return 33554431;
			prod <<= (-s);
		end
		return prod > 33554431 ? 33554431 : prod;
	endfunction

	function automatic note_t quantize(logic [23:0] freq);
		note_t o;
		longint r, sd, n, oct, nc, pc;
		o = '0;
		if (freq == 0) return o;
		r = pitch_reg == 0 ? 1 : pitch_reg;
		sd = (log2_fixed(freq) - log2_fixed(r)) * 12;
		n = sd >= 0 ? (sd + 32768) / 65536 : -((-sd + 32768) / 65536);
		oct = fdiv(n + 57, 12);
		if (oct > 15) oct = 15;
		if (oct < -16) oct = -16;
		pc = ((n % 12) + 21) % 12;
		nc = n * 10000 + longint'(offset_reg);
		o.valid_res = 1'b1;
		o.pitch_class = pc[3:0];
		o.octave_number = oct[4:0];
		o.is_sharp = (pc == 1 || pc == 3 || pc == 6 || pc == 8 || pc == 10);
		o.note_cents = nc[22:0];
		o.note_frequency = note_hz(r, nc) & 64'h1FFFFFF;
		return o;
	endfunction

	// driver: the front of the queue is the word on offer until it is accepted
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (s_axis_tvalid && s_axis_tready) begin
			note_queue.push_back(quantize(s_axis_tdata));
			void'(freq_queue.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			// hold the offered word
		end else if (freq_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= freq_queue[0];
		end else begin
			s_axis_tvalid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		note_t got, want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[8:4], m_axis_tdata[9],
				m_axis_tdata[32:10], m_axis_tdata[57:33]};
			if (note_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result word %h", got);
			end else begin
				want = note_queue.pop_front();
				if (got !== want || m_axis_tdata[63:58] !== '0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp v%0d pc%0d oct%0d s%0d c%0d f%0d, got v%0d pc%0d oct%0d s%0d c%0d f%0d",
							want.valid_res, want.pitch_class, $signed(want.octave_number),
							want.is_sharp, $signed(want.note_cents), want.note_frequency,
							got.valid_res, got.pitch_class, $signed(got.octave_number),
							got.is_sharp, $signed(got.note_cents), got.note_frequency);
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (cycles > LIMIT) begin
			$display("frequency_to_nearest_note verification failed");
			$finish;
		end
	end

	task automatic wait_drain();
		while (freq_queue.size() != 0 || note_queue.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [17:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PITCH) pitch_reg = value;
		else offset_reg = value[14:0];
		@(posedge clk);
	endtask

	function automatic logic [23:0] rand_freq();
		case ($urandom_range(3))
			0: return 24'($urandom_range(24'hFFFFFF));
			1: return 24'd1 << $urandom_range(23);
			2: return 24'($urandom_range(300000, 20000));
			default: return 24'($urandom_range(3000000) >> $urandom_range(12));
		endcase
	endfunction

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) freq_queue.push_back(rand_freq());
		wait_drain();
	endtask

	initial begin
		logic [17:0] pitches[4];
		logic [14:0] offsets[4];
		pitches = '{18'd25600, 18'd256000, 18'd0, 18'd112640};
		offsets = '{15'h7FFF, -15'sd10000, 15'sd10000, 15'sd0};
		roots[0] = 64'd1 << 31;
		for (int j = 1; j <= 16; j++) roots[j] = sq_root(roots[j - 1] << 30);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: zero, extremes, exact notes, half-semitone region
		freq_queue = '{24'd0, 24'd1, 24'hFFFFFF, 24'd112640, 24'd225280, 24'd56320,
			24'd119337, 24'd109434, 24'd115935, 24'd2, 24'h800000, 24'h555555,
			24'hAAAAAA, 24'd133952, 24'd126434};
		for (int i = 1; i < 12; i++) freq_queue.push_back(24'(112640 * (2.0 ** (i / 12.0))));
		wait_drain();
		// long receiver stall while the sender keeps offering
		hold_cycles = 200;
		random_phase(100);
		for (int i = 0; i < 4; i++) begin
			write_reg(CFG_PITCH, pitches[i]);
			write_reg(CFG_OFFSET, {3'b0, offsets[i]});
			if (i == 1) begin
				send_idle = 62;
				recv_idle = 10;
			end else if (i == 2) begin
				send_idle = 0;
				recv_idle = 0;
			end
			random_phase(220);
		end
		if (mismatches == 0) begin
			$display("frequency_to_nearest_note verification clean");
		end else begin
			$display("frequency_to_nearest_note verification failed");
		end
		$finish;
	end
endmodule

/* sim.f */
+incdir+hdl
hdl/ftnn_pkg.sv
hdl/ftnn_log2.sv
hdl/ftnn_exp2.sv
hdl/frequency_to_nearest_note.sv
test/frequency_to_nearest_note_test.sv
